[rtl/assert_macros.svh]
// Assertion helpers for the remainder unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRMU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRMU_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FRMU_ASSERT(lbl, clk, rst, prop, msg)
`define FRMU_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

[rtl/frmu_pkg.sv]
package frmu_pkg;

   localparam int MANT_W        = 64;
   localparam int MANT_BITS_DEF = 64;
   localparam int EXP_W         = 16;
   localparam int EXT_W         = 18;
   localparam int LEFT_W        = 17;
   localparam int QB_W          = 7;

   localparam logic [1:0] CLS_ZERO   = 2'd0;
   localparam logic [1:0] CLS_FINITE = 2'd1;
   localparam logic [1:0] CLS_INF    = 2'd2;
   localparam logic [1:0] CLS_NAN    = 2'd3;

   localparam logic OP_IEEE = 1'b0;
   localparam logic OP_MOD  = 1'b1;

   typedef struct packed {
      logic              op;
      logic              x_sign;
      logic [EXP_W-1:0]  x_exp;
      logic [MANT_W-1:0] x_mant;
      logic [1:0]        x_class;
      logic              y_sign;
      logic [EXP_W-1:0]  y_exp;
      logic [MANT_W-1:0] y_mant;
      logic [1:0]        y_class;
   } req_payload_type;

   typedef struct packed {
      logic              r_sign;
      logic [EXP_W-1:0]  r_exp;
      logic [MANT_W-1:0] r_mant;
      logic [1:0]        r_class;
      logic [QB_W-1:0]   quotient_bits;
      logic              quotient_sign;
      logic              quotient_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic norm_x;
      logic norm_y;
      logic check;
      logic div_step;
      logic round;
      logic norm_r;
   } cmd_type;

   typedef struct packed {
      logic x_norm_done;
      logic y_norm_done;
      logic chk_early;
      logic chk_div;
      logic div_exact;
      logic div_last;
      logic r_norm_done;
   } status_type;

endpackage

[rtl/frmu_req_if.sv]
interface frmu_req_if;
   import frmu_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic              x_sign;
   logic [EXP_W-1:0]  x_exp;
   logic [MANT_W-1:0] x_mant;
   logic [1:0]        x_class;
   logic              y_sign;
   logic [EXP_W-1:0]  y_exp;
   logic [MANT_W-1:0] y_mant;
   logic [1:0]        y_class;

   modport source (output valid, op, x_sign, x_exp, x_mant, x_class,
                   y_sign, y_exp, y_mant, y_class, input ready);
   modport sink (input valid, op, x_sign, x_exp, x_mant, x_class,
                 y_sign, y_exp, y_mant, y_class, output ready);
endinterface

[rtl/frmu_rsp_if.sv]
interface frmu_rsp_if;
   import frmu_pkg::*;
   logic              valid;
   logic              ready;
   logic              r_sign;
   logic [EXP_W-1:0]  r_exp;
   logic [MANT_W-1:0] r_mant;
   logic [1:0]        r_class;
   logic [QB_W-1:0]   quotient_bits;
   logic              quotient_sign;
   logic              quotient_valid;

   modport source (output valid, r_sign, r_exp, r_mant, r_class, quotient_bits,
                   quotient_sign, quotient_valid, input ready);
   modport sink (input valid, r_sign, r_exp, r_mant, r_class, quotient_bits,
                 quotient_sign, quotient_valid, output ready);
endinterface

[rtl/frmu_ctrl.sv]
module frmu_ctrl
   import frmu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_NORM_X = 3'd1;
   localparam logic [2:0] ST_NORM_Y = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_ROUND  = 3'd5;
   localparam logic [2:0] ST_NORM_R = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;

   // Both handshakes stay closed while reset is held, so no beat is taken
   // or delivered that the reset would then throw away.
   assign in_ready  = (state_ff == ST_IDLE) && !reset;
   assign out_valid = (state_ff == ST_DONE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM_X;
            end
         end
         ST_NORM_X: begin
            cmd.norm_x = 1'b1;
            if (status.x_norm_done) state_in = ST_NORM_Y;
         end
         ST_NORM_Y: begin
            cmd.norm_y = 1'b1;
            if (status.y_norm_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.chk_early) state_in = ST_DONE;
            else if (status.chk_div) state_in = ST_DIV;
            else state_in = ST_NORM_R;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_exact) state_in = ST_DONE;
            else if (status.div_last) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_NORM_R;
         end
         ST_NORM_R: begin
            cmd.norm_r = 1'b1;
            if (status.r_norm_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

[rtl/frmu_datapath.sv]
module frmu_datapath
   import frmu_pkg::*;
#(
   parameter int MANT_BITS = MANT_BITS_DEF
) (
   input  logic            clock,
   input  req_payload_type req,
   input  cmd_type         cmd,
   output status_type      status,
   output rsp_payload_type rsp
);

   localparam logic [MANT_W-1:0] MANT_MASK = ~{MANT_W{1'b0}} << (MANT_W - MANT_BITS);

   logic                    mode_ff, mode_in;
   logic                    xs_ff, xs_in, ys_ff, ys_in;
   logic signed [EXT_W-1:0] xe_ff, xe_in, ye_ff, ye_in;
   logic [MANT_W-1:0]       xm_ff, xm_in, ym_ff, ym_in;
   logic [1:0]              xc_ff, xc_in, yc_ff, yc_in;
   logic [MANT_W-1:0]       acc_ff, acc_in;
   logic                    carry_ff, carry_in, neg_ff, neg_in;
   logic [QB_W-1:0]         quo_ff, quo_in;
   logic [LEFT_W-1:0]       left_ff, left_in;
   logic signed [EXT_W-1:0] rex_ff, rex_in;
   rsp_payload_type         rsp_ff, rsp_in;

   logic [MANT_W-1:0]       xm_ld, ym_ld, sub_acc, sh_acc, dbl;
   logic [1:0]              xc_ld, yc_ld;
   logic signed [EXT_W-1:0] diff;
   logic                    invalid, pass, take, gt, eq;
   logic [QB_W-1:0]         q_inc, q_sel;

   always_comb begin
      xm_ld = req.x_mant & MANT_MASK;
      ym_ld = req.y_mant & MANT_MASK;
      xc_ld = req.x_class;
      yc_ld = req.y_class;
      if (xc_ld == CLS_FINITE && xm_ld == '0) xc_ld = CLS_ZERO;
      if (yc_ld == CLS_FINITE && ym_ld == '0) yc_ld = CLS_ZERO;
   end

   assign diff    = xe_ff - ye_ff;
   assign invalid = (xc_ff == CLS_NAN) || (yc_ff == CLS_NAN) || (xc_ff == CLS_INF)
                    || (yc_ff == CLS_ZERO);
   assign pass    = (xc_ff == CLS_ZERO) || (yc_ff == CLS_INF);
   assign take    = carry_ff || (acc_ff > ym_ff);
   assign sub_acc = take ? (acc_ff - ym_ff) : acc_ff;
   assign q_inc   = quo_ff + 7'd1;
   assign q_sel   = take ? q_inc : quo_ff;
   assign sh_acc  = {sub_acc[MANT_W-2:0], 1'b0};
   assign dbl     = {acc_ff[MANT_W-2:0], 1'b0};
   assign gt      = acc_ff[MANT_W-1] || (dbl > ym_ff);
   assign eq      = !acc_ff[MANT_W-1] && (dbl == ym_ff);

   assign status.x_norm_done = !(xc_ff == CLS_FINITE && !xm_ff[MANT_W-1]);
   assign status.y_norm_done = !(yc_ff == CLS_FINITE && !ym_ff[MANT_W-1]);
   assign status.chk_early   = invalid || pass;
   assign status.chk_div     = !diff[EXT_W-1];
   assign status.div_exact   = !carry_ff && (acc_ff == ym_ff);
   assign status.div_last    = (left_ff == '0);
   assign status.r_norm_done = acc_ff[MANT_W-1];

   always_comb begin
      mode_in  = mode_ff;
      xs_in    = xs_ff;   xe_in = xe_ff;   xm_in = xm_ff;   xc_in = xc_ff;
      ys_in    = ys_ff;   ye_in = ye_ff;   ym_in = ym_ff;   yc_in = yc_ff;
      acc_in   = acc_ff;  carry_in = carry_ff;  neg_in = neg_ff;
      quo_in   = quo_ff;  left_in = left_ff;    rex_in = rex_ff;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         mode_in = req.op;
         xs_in   = req.x_sign;
         ys_in   = req.y_sign;
         xc_in   = xc_ld;
         yc_in   = yc_ld;
         xm_in   = (xc_ld == CLS_ZERO) ? '0 : xm_ld;
         ym_in   = (yc_ld == CLS_ZERO) ? '0 : ym_ld;
         xe_in   = (xc_ld == CLS_ZERO) ? '0 : EXT_W'($signed(req.x_exp));
         ye_in   = (yc_ld == CLS_ZERO) ? '0 : EXT_W'($signed(req.y_exp));
         quo_in  = '0;
      end

      if (cmd.norm_x && !status.x_norm_done) begin
         xm_in = {xm_ff[MANT_W-2:0], 1'b0};
         xe_in = xe_ff - 18'sd1;
      end

      if (cmd.norm_y && !status.y_norm_done) begin
         ym_in = {ym_ff[MANT_W-2:0], 1'b0};
         ye_in = ye_ff - 18'sd1;
      end

      if (cmd.check) begin
         neg_in   = xs_ff;
         acc_in   = xm_ff;
         carry_in = 1'b0;
         left_in  = diff[LEFT_W-1:0];
         rex_in   = xe_ff;
         rsp_in.quotient_sign  = xs_ff ^ ys_ff;
         rsp_in.quotient_valid = 1'b1;
         if (invalid) begin
            rsp_in.r_sign         = 1'b0;
            rsp_in.r_exp          = '0;
            rsp_in.r_mant         = MANT_MASK;
            rsp_in.r_class        = CLS_NAN;
            rsp_in.quotient_bits  = '0;
            rsp_in.quotient_sign  = 1'b0;
            rsp_in.quotient_valid = 1'b0;
         end else if (pass) begin
            rsp_in.r_sign        = xs_ff;
            rsp_in.r_exp         = xe_ff[EXP_W-1:0];
            rsp_in.r_mant        = xm_ff;
            rsp_in.r_class       = xc_ff;
            rsp_in.quotient_bits = '0;
         end else if (diff[EXT_W-1]) begin
            // Dividend below divisor: only IEEE x > y/2 moves the quotient.
            if (mode_ff == OP_IEEE && diff == -18'sd1 && xm_ff > ym_ff) begin
               acc_in = ym_ff - (xm_ff - ym_ff);
               neg_in = !xs_ff;
               quo_in = 7'd1;
            end
         end
      end

      if (cmd.div_step) begin
         if (status.div_exact) begin
            rsp_in.r_sign        = 1'b0;
            rsp_in.r_exp         = '0;
            rsp_in.r_mant        = '0;
            rsp_in.r_class       = CLS_ZERO;
            rsp_in.quotient_bits = (left_ff < 17'd7) ? (q_inc << left_ff[2:0]) : '0;
         end else if (status.div_last) begin
            acc_in   = sub_acc;
            quo_in   = q_sel;
            carry_in = 1'b0;
         end else begin
            left_in  = left_ff - 17'd1;
            quo_in   = {q_sel[QB_W-2:0], 1'b0};
            carry_in = sub_acc[MANT_W-1];
            acc_in   = sh_acc;
         end
      end

      if (cmd.round) begin
         rex_in = ye_ff;
         if (mode_ff == OP_IEEE && (gt || (eq && quo_ff[0]))) begin
            acc_in = ym_ff - acc_ff;
            neg_in = !neg_ff;
            quo_in = q_inc;
         end
      end

      if (cmd.norm_r) begin
         if (acc_ff[MANT_W-1]) begin
            rsp_in.r_sign        = neg_ff;
            rsp_in.r_exp         = rex_ff[EXP_W-1:0];
            rsp_in.r_mant        = acc_ff;
            rsp_in.r_class       = CLS_FINITE;
            rsp_in.quotient_bits = quo_ff;
         end else begin
            acc_in = {acc_ff[MANT_W-2:0], 1'b0};
            rex_in = rex_ff - 18'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      xs_ff    <= xs_in;   xe_ff <= xe_in;   xm_ff <= xm_in;   xc_ff <= xc_in;
      ys_ff    <= ys_in;   ye_ff <= ye_in;   ym_ff <= ym_in;   yc_ff <= yc_in;
      acc_ff   <= acc_in;  carry_ff <= carry_in;  neg_ff <= neg_in;
      quo_ff   <= quo_in;  left_ff <= left_in;    rex_ff <= rex_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

[rtl/float_remainder_modulo_unit_core.sv]
// Extended-precision floating-point remainder and modulo unit.
//
// The request channel carries one beat per operation: the mode (IEEE
// remainder with ties to even, or truncating modulo) and two operands as
// sign, unbiased exponent, 64-bit mantissa and class. The response channel
// returns one beat per request: the exact normalized remainder, its class,
// the low seven quotient bits, the quotient sign and a quotient valid flag.
//
// One operation is in flight at a time; req ready is high only while the
// unit is idle, and the next request can be taken in the cycle after the
// response beat is delivered. After a request is accepted, the unit
// normalizes the dividend and then the divisor by left shifts, runs one
// check step, then D + 1 shift-subtract steps where D is the exponent
// difference, one rounding step, and finally normalizes the remainder by
// left shifts. The shift-subtract loop produces one quotient bit per cycle
// through a single 64-bit subtractor and dominates the run time at the
// widest exponent spread. A negative difference skips the loop and the
// rounding step; an exact match in the loop ends the operation there;
// invalid and pass-through cases end after the check step.
//
// Reset returns the controller to idle and holds both handshakes low. A
// stalled receiver holds the response beat in its output register, and no
// new request is taken until that beat is delivered.
`include "assert_macros.svh"

module float_remainder_modulo_unit_core
   import frmu_pkg::*;
#(
   parameter int MANT_BITS = MANT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   frmu_req_if.sink          req_chan,
   frmu_rsp_if.source        rsp_chan
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_pl;
   rsp_payload_type rsp_pl;
   logic            no_quotient, finite_out, stalled;

   // Gather the request fields into one payload word for the datapath.
   assign req_pl = '{op: req_chan.op, x_sign: req_chan.x_sign, x_exp: req_chan.x_exp,
                     x_mant: req_chan.x_mant, x_class: req_chan.x_class,
                     y_sign: req_chan.y_sign, y_exp: req_chan.y_exp,
                     y_mant: req_chan.y_mant, y_class: req_chan.y_class};

   frmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   frmu_datapath #(.MANT_BITS(MANT_BITS)) u_datapath (
      .clock  (clock),
      .req    (req_pl),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_pl)
   );

   // The response beat comes straight from the result register.
   assign rsp_chan.r_sign         = rsp_pl.r_sign;
   assign rsp_chan.r_exp          = rsp_pl.r_exp;
   assign rsp_chan.r_mant         = rsp_pl.r_mant;
   assign rsp_chan.r_class        = rsp_pl.r_class;
   assign rsp_chan.quotient_bits  = rsp_pl.quotient_bits;
   assign rsp_chan.quotient_sign  = rsp_pl.quotient_sign;
   assign rsp_chan.quotient_valid = rsp_pl.quotient_valid;

   // Short names for the conditions that the checks below start from.
   assign no_quotient = rsp_chan.valid && !rsp_chan.quotient_valid;
   assign finite_out  = rsp_chan.valid && (rsp_chan.r_class == CLS_FINITE);
   assign stalled     = rsp_chan.valid && !rsp_chan.ready;

   // The unit never takes a request while a response is pending.
   `FRMU_NEVER(a_one_in_flight, clock, reset, req_chan.ready && rsp_chan.valid, "busy overlap")
   // A cleared quotient flag only goes with the default NaN.
   `FRMU_ASSERT(a_nan_flag, clock, reset, no_quotient |-> rsp_chan.r_class == CLS_NAN, "no NaN")
   // A finite remainder is always delivered normalized.
   `FRMU_ASSERT(a_norm_out, clock, reset, finite_out |-> rsp_chan.r_mant[MANT_W-1], "bad mantissa")
   // A stalled response stays presented.
   `FRMU_ASSERT(a_hold, clock, reset, stalled |=> rsp_chan.valid, "response dropped")

endmodule

[tb/frmu_tb_if.sv]
`timescale 1ns / 100ps
// The block's own channel interfaces come from the RTL; this file holds the
// testbench-side constants shared by the stimulus.
package frmu_tb_pkg;
   import frmu_pkg::*;

   // A mantissa of exactly one: only the explicit leading bit is set.
   localparam logic [MANT_W-1:0] MANT_ONE = 64'h8000_0000_0000_0000;
endpackage

[tb/frmu_remainder_checker.sv]
`timescale 1ns / 100ps
module frmu_remainder_checker
   import frmu_pkg::*;
#(
   parameter int MANT_BITS = MANT_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   frmu_req_if    req_chan,
   frmu_rsp_if    rsp_chan,
   output int     fail_count,
   output int     pending_count
);
   localparam logic [MANT_W-1:0] KEEP_MASK = ~64'd0 << (64 - MANT_BITS);

   rsp_payload_type expected_results[$];
   int              mismatch_total = 0;

   assign fail_count = mismatch_total;

   // Normalize one operand: a finite value with a clear top bit is shifted
   // up and its exponent lowered; a finite value with no bits is a zero.
   task automatic load_operand(input logic s, input logic [15:0] e, input logic [63:0] m,
                               input logic [1:0] c, output logic os,
                               output int oe, output logic [63:0] om, output logic [1:0] oc);
      int n;
      os = s;
      oe = $signed(e);
      om = m & KEEP_MASK;
      oc = c;
      n = 0;
      if (oc == CLS_FINITE) begin
         if (om == 0) begin
            oc = CLS_ZERO;
         end else begin
            while (n < 63 && !om[63]) begin
               om = om << 1;
               n++;
            end
            oe = oe - n;
         end
      end
      if (oc == CLS_ZERO) begin
         oe = 0;
         om = 0;
      end
   endtask

   function automatic rsp_payload_type pack_result(logic s, int e, logic [63:0] m,
                                                   logic [1:0] c, int qb, logic qs,
                                                   logic qv);
      rsp_payload_type r;
      r.r_sign = s;
      r.r_exp = e[15:0];
      r.r_mant = m;
      r.r_class = c;
      r.quotient_bits = qb[6:0];
      r.quotient_sign = qs;
      r.quotient_valid = qv;
      return r;
   endfunction

   task automatic predict_remainder(input req_payload_type q, output rsp_payload_type r);
      logic xs, ys, qsign, neg, carry, top, gt, eq;
      int xe, ye, diff, rex, left, quo, n;
      logic [63:0] xm, ym, acc;
      logic [1:0] xc, yc;
      load_operand(q.x_sign, q.x_exp, q.x_mant, q.x_class, xs, xe, xm, xc);
      load_operand(q.y_sign, q.y_exp, q.y_mant, q.y_class, ys, ye, ym, yc);
      quo = 0;
      if (xc == CLS_NAN || yc == CLS_NAN || xc == CLS_INF || yc == CLS_ZERO) begin
         r = pack_result(1'b0, 0, KEEP_MASK, CLS_NAN, 0, 1'b0, 1'b0);
         return;
      end
      qsign = xs ^ ys;
      if (xc == CLS_ZERO || yc == CLS_INF) begin
         r = pack_result(xs, xe, xm, xc, 0, qsign, 1'b1);
         return;
      end
      diff = xe - ye;
      neg = xs;
      if (diff >= 0) begin
         left = diff;
         carry = 0;
         acc = xm;
         forever begin
            // Partial remainder hits the divisor exactly: zero result, and
            // the quotient still owes the remaining shifts.
            if (!carry && acc == ym) begin
               quo = quo + 1;
               quo = (left < 7) ? ((quo << left) & 'h7f) : 0;
               r = pack_result(1'b0, 0, 64'd0, CLS_ZERO, quo, qsign, 1'b1);
               return;
            end
            if (carry || acc > ym) begin
               acc = acc - ym;
               carry = 0;
               quo = (quo + 1) & 'h7f;
            end
            if (left == 0) break;
            left--;
            quo = (quo << 1) & 'h7f;
            carry = acc[63];
            acc = acc << 1;
         end
         rex = ye;
         if (q.op == OP_IEEE) begin
            top = acc[63];
            gt = top || ((acc << 1) > ym);
            eq = !top && ((acc << 1) == ym);
            if (gt || (eq && quo[0])) begin
               acc = ym - acc;
               neg = ~neg;
               quo = (quo + 1) & 'h7f;
            end
         end
      end else begin
         acc = xm;
         rex = xe;
         if (q.op == OP_IEEE && diff == -1 && xm > ym) begin
            acc = ym - (xm - ym);
            neg = ~neg;
            quo = 1;
         end
      end
      n = 0;
      while (n < 63 && !acc[63]) begin
         acc = acc << 1;
         n++;
      end
      r = pack_result(neg, rex - n, acc, CLS_FINITE, quo, qsign, 1'b1);
   endtask

   always @(posedge clock) begin
      req_payload_type q;
      rsp_payload_type want, got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            q = '{req_chan.op, req_chan.x_sign, req_chan.x_exp, req_chan.x_mant,
                  req_chan.x_class, req_chan.y_sign, req_chan.y_exp, req_chan.y_mant,
                  req_chan.y_class};
            predict_remainder(q, want);
            expected_results.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.r_sign, rsp_chan.r_exp, rsp_chan.r_mant, rsp_chan.r_class,
                    rsp_chan.quotient_bits, rsp_chan.quotient_sign,
                    rsp_chan.quotient_valid};
            if (expected_results.size() == 0) begin
               $error("unexpected response beat");
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               if (got.r_sign !== want.r_sign) begin
                  $error("r_sign exp %0h got %0h", want.r_sign, got.r_sign);
                  mismatch_total++;
               end
               if (got.r_exp !== want.r_exp) begin
                  $error("r_exp exp %0h got %0h", want.r_exp, got.r_exp);
                  mismatch_total++;
               end
               if (got.r_mant !== want.r_mant) begin
                  $error("r_mant exp %0h got %0h", want.r_mant, got.r_mant);
                  mismatch_total++;
               end
               if (got.r_class !== want.r_class) begin
                  $error("r_class exp %0h got %0h", want.r_class, got.r_class);
                  mismatch_total++;
               end
               if (got.quotient_bits !== want.quotient_bits) begin
                  $error("quotient_bits exp %0h got %0h", want.quotient_bits,
                         got.quotient_bits);
                  mismatch_total++;
               end
               if (got.quotient_sign !== want.quotient_sign) begin
                  $error("quotient_sign exp %0h got %0h", want.quotient_sign,
                         got.quotient_sign);
                  mismatch_total++;
               end
               if (got.quotient_valid !== want.quotient_valid) begin
                  $error("quotient_valid exp %0h got %0h", want.quotient_valid,
                         got.quotient_valid);
                  mismatch_total++;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end
endmodule

[tb/float_remainder_modulo_unit_core_test.sv]
`timescale 1ns / 100ps
// Top of the remainder unit testbench. It owns the clock, the single reset,
// the request stimulus and the receiver's stalls; the checker beside the
// block predicts and compares every response beat.
module float_remainder_modulo_unit_core_test
   import frmu_pkg::*, frmu_tb_pkg::*;
;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_count;

   frmu_req_if req_chan ();
   frmu_rsp_if rsp_chan ();

   float_remainder_modulo_unit_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frmu_remainder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one, and often none at all.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls at random on its own schedule.
   initial begin
      int hold;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            rsp_chan.ready = ~rsp_chan.ready;
            hold = rsp_chan.ready ? $urandom_range(0, 8) : gap_length();
         end
      end
   end

   // Present one beat and hold it until the block takes it.
   task automatic send_beat(input req_payload_type q);
      int idle;
      idle = gap_length();
      repeat (idle) @(negedge clock);
      req_chan.op      = q.op;
      req_chan.x_sign  = q.x_sign;
      req_chan.x_exp   = q.x_exp;
      req_chan.x_mant  = q.x_mant;
      req_chan.x_class = q.x_class;
      req_chan.y_sign  = q.y_sign;
      req_chan.y_exp   = q.y_exp;
      req_chan.y_mant  = q.y_mant;
      req_chan.y_class = q.y_class;
      req_chan.valid   = 1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 0;
   endtask

   function automatic logic [63:0] random_mant();
      return {$urandom, $urandom};
   endfunction

   // Exponent spreads stay small so that the shift-subtract loop is short;
   // a rare item spans the full range to exercise the long loop.
   function automatic req_payload_type random_beat();
      req_payload_type q;
      int base, spread, pick;
      q.op = 1'($urandom_range(0, 1));
      q.x_sign = 1'($urandom_range(0, 1));
      q.y_sign = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      base = $urandom_range(0, 60000) - 30000;
      spread = (pick < 3) ? $urandom_range(0, 32000) : $urandom_range(0, 80) - 10;
      q.x_exp = 16'(base + spread);
      q.y_exp = 16'(base);
      if (pick >= 3 && pick < 6) begin
         q.x_exp = 16'(16383);
         q.y_exp = 16'(-16445);
      end
      q.x_mant = random_mant() | MANT_ONE;
      q.y_mant = random_mant() | MANT_ONE;
      if ($urandom_range(0, 9) == 0) q.x_mant = random_mant() >> $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) q.y_mant = random_mant() >> $urandom_range(0, 63);
      // Divisor mantissa equal to the dividend's gives exact matches and half-way ties.
      if ($urandom_range(0, 7) == 0) q.y_mant = q.x_mant;
      q.x_class = CLS_FINITE;
      q.y_class = CLS_FINITE;
      if ($urandom_range(0, 9) == 0) q.x_class = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) q.y_class = 2'($urandom_range(0, 3));
      return q;
   endfunction

   function automatic req_payload_type make_beat(logic op, logic xs, int xe,
                                                 logic [63:0] xm, logic [1:0] xc,
                                                 logic ys, int ye, logic [63:0] ym,
                                                 logic [1:0] yc);
      return '{op, xs, xe[15:0], xm, xc, ys, ye[15:0], ym, yc};
   endfunction

   localparam logic [63:0] ONE = MANT_ONE;

   initial begin
      req_payload_type directed[$];
      req_chan.valid = 0;
      req_chan.op = 0;
      req_chan.x_sign = 0;
      req_chan.x_exp = 0;
      req_chan.x_mant = 0;
      req_chan.x_class = 0;
      req_chan.y_sign = 0;
      req_chan.y_exp = 0;
      req_chan.y_mant = 0;
      req_chan.y_class = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Invalid operations: NaN on either side, infinite dividend, zero divisor.
      directed.push_back(make_beat(OP_IEEE, 0, 0, ONE, CLS_NAN, 0, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_MOD, 1, 0, ONE, CLS_FINITE, 1, 0, ONE, CLS_NAN));
      directed.push_back(make_beat(OP_MOD, 0, 5, ONE, CLS_INF, 0, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 0, 5, ONE, CLS_FINITE, 0, 0, ONE, CLS_ZERO));
      // Finite divisor with an all-zero mantissa counts as zero.
      directed.push_back(make_beat(OP_IEEE, 0, 5, ONE, CLS_FINITE, 0, 3, 0, CLS_FINITE));
      // Pass-through: zero dividend, infinite divisor.
      directed.push_back(make_beat(OP_IEEE, 1, 9, ONE, CLS_ZERO, 0, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_MOD, 1, -3, 64'h1234, CLS_FINITE, 1, 0, ONE,
                                   CLS_INF));
      // Exact matches, with quotient shifts left over within the seven bits and past them.
      directed.push_back(make_beat(OP_MOD, 0, 3, ONE, CLS_FINITE, 1, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 1, 20, 64'hC000_0000_0000_0000, CLS_FINITE,
                                   0, 0, 64'hC000_0000_0000_0000, CLS_FINITE));
      // Ties: 5 rem 2 and 7 rem 2 round to even in opposite directions.
      directed.push_back(make_beat(OP_IEEE, 0, 2, 64'hA000_0000_0000_0000, CLS_FINITE,
                                   0, 1, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 0, 2, 64'hE000_0000_0000_0000, CLS_FINITE,
                                   0, 1, ONE, CLS_FINITE));
      // Negative difference, including the minus-one case that flips sign.
      directed.push_back(make_beat(OP_IEEE, 0, -1, 64'hF000_0000_0000_0000, CLS_FINITE,
                                   0, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_MOD, 0, -1, 64'hF000_0000_0000_0000, CLS_FINITE,
                                   0, 0, ONE, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 1, -40, ~64'd0, CLS_FINITE, 0, 0, ONE,
                                   CLS_FINITE));
      // Unnormalized operands on both sides.
      directed.push_back(make_beat(OP_MOD, 0, 10, 64'd1, CLS_FINITE, 0, 0, 64'h3, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 1, 0, 64'h0000_0F00_0000_0001, CLS_FINITE,
                                   1, -70, 64'h7FFF_FFFF_FFFF_FFFF, CLS_FINITE));
      // Extremes of the exponent range and mantissa values.
      directed.push_back(make_beat(OP_MOD, 1, 16383, ~64'd0, CLS_FINITE, 0, -16445,
                                   ONE | 64'd1, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 0, -32768, ONE, CLS_FINITE, 1, 32767,
                                   ~64'd0, CLS_FINITE));
      directed.push_back(make_beat(OP_IEEE, 1, 0, ~64'd0, CLS_FINITE, 1, 0, ~64'd0 - 1,
                                   CLS_FINITE));

      foreach (directed[i]) send_beat(directed[i]);

      for (int i = 0; i < 80; i++) begin
         send_beat(random_beat());
         // Once midway, hold the sender back until no response is pending.
         if (i == 40) begin
            while (pending_count != 0) @(negedge clock);
         end
      end

      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // About 100 items, even if every one had the widest possible exponent
   // spread, stay far below this bound.
   initial begin
      #(12 * 30_000_000);
      $display("CHECK FAILED");
      $finish;
   end
endmodule

[float_remainder_modulo_unit_core.f]
+incdir+rtl
rtl/frmu_pkg.sv
rtl/frmu_req_if.sv
rtl/frmu_rsp_if.sv
rtl/frmu_ctrl.sv
rtl/frmu_datapath.sv
rtl/float_remainder_modulo_unit_core.sv
tb/frmu_tb_if.sv
tb/frmu_remainder_checker.sv
tb/float_remainder_modulo_unit_core_test.sv
